>>> hdl/rmcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rmcc_pkg;

    localparam int MAX_NODES = 32;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);

    typedef logic [MAX_NODES-1:0] row_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef enum logic [2:0] {
        KIND_LOAD    = 3'd0,
        KIND_REBUILD = 3'd1,
        KIND_ADD     = 3'd2,
        KIND_LONE    = 3'd3,
        KIND_CYCLE   = 3'd4,
        KIND_MUTUAL  = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_PIVOT,
        ST_SWEEP,
        ST_GATHER,
        ST_MERGE,
        ST_SCAN,
        ST_LONE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic we;
        idx_t addr;
        row_t data;
    } row_wr_t;

    function automatic row_t low_mask(input cnt_t n);
        row_t m;
        m = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
            m[i] = (CNT_W'(i) < n);
        end
        return m;
    endfunction

    function automatic row_t self_bit(input idx_t i);
        row_t m;
        m = '0;
        m[i] = 1'b1;
        return m;
    endfunction

endpackage

`default_nettype wire

>>> hdl/rmcc_rows.sv
`timescale 1ns / 1ps
`default_nettype none

module rmcc_rows
    import rmcc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire row_wr_t wr,
    input  wire idx_t    rd_addr,
    output row_t         rd_data
);

    row_t rows_reg [MAX_NODES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_NODES; i++)
            begin
                rows_reg[i] <= '0;
            end
        end
        else if (wr.we)
        begin
            rows_reg[wr.addr] <= wr.data;
        end
    end

    assign rd_data = rows_reg[rd_addr];

endmodule

`default_nettype wire

>>> hdl/reachability_matrix_cycle_check.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencing: a row load or an unused kind goes straight to the result, a lone node
// updates its own row, a cycle query scans every row, an add node gathers and then merges
// over every row, and a mutual query and a rebuild (after an init pass) sweep every row for
// each pivot, all through the one read port and one write port of the reach matrix.
// Throughput: one item at a time; the input is not ready until the result is registered.
// Reset clears the reach matrix, the live row count and the control; edge rows are not reset.

module reachability_matrix_cycle_check
    import rmcc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // node_index[4:0], node_count[10:5], out_mask[42:11], in_mask[74:43],
    // valid_mask[106:75], zero pad[111:107]
    input  wire logic [111:0] s_axis_tdata,
    // kind[2:0]
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // cycle_found[0], zero pad[7:1]
    output logic [7:0]        m_axis_tdata
);

    state_t  state_reg, state_next;
    kind_t   kind_reg;
    idx_t    idx_reg, piv_reg, id_reg;
    cnt_t    row_count_reg;
    row_t    lim_reg, a_reg, b_reg, acc_reg, pivot_reg;
    logic    found_reg;
    logic    m_valid_reg, cycle_found_reg;
    row_t    edge_rows [MAX_NODES];

    idx_t    rd_addr;
    row_t    rd_data;
    row_wr_t wr;

    logic    accept, idx_last, piv_last, out_free;
    kind_t   in_kind;
    idx_t    in_id;
    logic [5:0] in_count;
    row_t    in_out, in_in, in_valid;
    cnt_t    rebuild_n, add_c, id_plus;
    row_t    acc_mask;

    assign in_kind  = kind_t'(s_axis_tuser);
    assign in_id    = s_axis_tdata[4:0];
    assign in_count = s_axis_tdata[10:5];
    assign in_out   = s_axis_tdata[42:11];
    assign in_in    = s_axis_tdata[74:43];
    assign in_valid = s_axis_tdata[106:75];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign idx_last      = (idx_reg == IDX_W'(MAX_NODES - 1));
    assign piv_last      = (piv_reg == IDX_W'(MAX_NODES - 1));
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign rebuild_n = (in_count > 6'(MAX_NODES)) ? CNT_W'(MAX_NODES) : CNT_W'(in_count);
    assign id_plus   = CNT_W'(in_id) + CNT_W'(1);
    assign add_c     = (id_plus > row_count_reg) ? id_plus : row_count_reg;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, cycle_found_reg};

    rmcc_rows u_rows (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_kind)
                        KIND_REBUILD: state_next = ST_INIT;
                        KIND_ADD:     state_next = ST_GATHER;
                        KIND_LONE:    state_next = ST_LONE;
                        KIND_CYCLE:   state_next = ST_SCAN;
                        KIND_MUTUAL:  state_next = ST_PIVOT;
                        default:      state_next = ST_DONE;
                    endcase
                end
            end
            ST_INIT:   if (idx_last) state_next = ST_PIVOT;
            ST_PIVOT:  state_next = ST_SWEEP;
            ST_SWEEP:
            begin
                if (idx_last)
                begin
                    state_next = piv_last ? ST_DONE : ST_PIVOT;
                end
            end
            ST_GATHER: if (idx_last) state_next = ST_MERGE;
            ST_MERGE:  if (idx_last) state_next = ST_DONE;
            ST_SCAN:   if (idx_last) state_next = ST_DONE;
            ST_LONE:   state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        rd_addr = idx_reg;
        wr      = '0;
        wr.addr = idx_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                wr.we   = 1'b1;
                wr.data = lim_reg[idx_reg] ? (self_bit(idx_reg) | (edge_rows[idx_reg] & lim_reg))
                                           : '0;
            end
            ST_PIVOT:
            begin
                rd_addr = piv_reg;
            end
            ST_SWEEP:
            begin
                if (kind_reg == KIND_REBUILD && rd_data[piv_reg])
                begin
                    wr.we   = 1'b1;
                    wr.data = rd_data | pivot_reg;
                end
            end
            ST_MERGE:
            begin
                if (idx_reg == id_reg)
                begin
                    wr.we   = 1'b1;
                    wr.data = acc_reg;
                end
                else if ((rd_data & b_reg) != '0)
                begin
                    wr.we   = 1'b1;
                    wr.data = rd_data | acc_reg;
                end
            end
            ST_LONE:
            begin
                rd_addr = id_reg;
                wr.we   = 1'b1;
                wr.addr = id_reg;
                wr.data = (rd_data & lim_reg) | self_bit(id_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign acc_mask = (a_reg[idx_reg] || idx_reg == id_reg) ? (rd_data & lim_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            piv_reg       <= '0;
            row_count_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                idx_reg <= '0;
                piv_reg <= '0;
                if (in_kind == KIND_REBUILD)
                begin
                    row_count_reg <= rebuild_n;
                end
                else if (in_kind == KIND_ADD || in_kind == KIND_LONE)
                begin
                    row_count_reg <= add_c;
                end
            end
            else if (state_reg == ST_INIT || state_reg == ST_SWEEP || state_reg == ST_GATHER
                     || state_reg == ST_MERGE || state_reg == ST_SCAN)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (state_reg == ST_SWEEP && idx_last)
                begin
                    piv_reg <= piv_reg + IDX_W'(1);
                end
            end
            if (state_reg == ST_DONE && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= in_kind;
            id_reg    <= in_id;
            found_reg <= 1'b0;
            unique case (in_kind)
                KIND_REBUILD:
                begin
                    lim_reg <= low_mask(rebuild_n);
                end
                KIND_ADD, KIND_LONE:
                begin
                    lim_reg <= low_mask(add_c);
                    a_reg   <= in_out & low_mask(add_c);
                    b_reg   <= in_in & low_mask(add_c);
                    acc_reg <= self_bit(in_id) | (in_out & low_mask(add_c));
                end
                KIND_CYCLE:
                begin
                    lim_reg   <= low_mask(row_count_reg);
                    a_reg     <= in_out & low_mask(row_count_reg);
                    b_reg     <= in_in & low_mask(row_count_reg);
                    found_reg <= ((in_out & in_in & low_mask(row_count_reg)) != '0);
                end
                KIND_MUTUAL:
                begin
                    lim_reg <= low_mask(row_count_reg);
                    b_reg   <= in_valid & low_mask(row_count_reg);
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            unique case (state_reg)
                ST_PIVOT:
                begin
                    pivot_reg <= rd_data;
                end
                ST_SWEEP:
                begin
                    if (kind_reg == KIND_MUTUAL && b_reg[piv_reg] && b_reg[idx_reg]
                        && idx_reg != piv_reg && pivot_reg[idx_reg] && rd_data[piv_reg])
                    begin
                        found_reg <= 1'b1;
                    end
                end
                ST_GATHER:
                begin
                    acc_reg <= acc_reg | acc_mask;
                end
                ST_SCAN:
                begin
                    if (a_reg[idx_reg] && (rd_data & b_reg) != '0)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == ST_DONE && out_free)
        begin
            cycle_found_reg <= found_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_kind == KIND_LOAD)
        begin
            edge_rows[in_id] <= in_out;
        end
    end

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again before the item finished");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg <= CNT_W'(MAX_NODES))
        else $error("live row count beyond the matrix size");

    a_found_query: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && found_reg)
        |-> (kind_reg == KIND_CYCLE || kind_reg == KIND_MUTUAL))
        else $error("cycle flag raised by an item that is not a query");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr.we |-> (state_reg == ST_INIT || state_reg == ST_SWEEP || state_reg == ST_MERGE
                   || state_reg == ST_LONE))
        else $error("reach row written outside an update phase");
`endif

endmodule

`default_nettype wire
